>>> hw/rtl/aalu_pkg.sv
// ----------------------------------------------------------------------------
// aalu_pkg: shared types and constants for the accumulator alu
// operation codes, request and result words, and the architectural state.
// ----------------------------------------------------------------------------
package aalu_pkg;

	// operation codes; codes 22 to 31 are no-ops
	typedef enum logic [4:0] {
		OP_ADD   = 5'd0,
		OP_ADDC  = 5'd1,
		OP_AND   = 5'd2,
		OP_OR    = 5'd3,
		OP_XOR   = 5'd4,
		OP_LOAD  = 5'd5,
		OP_XCH   = 5'd6,
		OP_XCHD  = 5'd7,
		OP_CLRA  = 5'd8,
		OP_CPLA  = 5'd9,
		OP_INCA  = 5'd10,
		OP_DECA  = 5'd11,
		OP_DA    = 5'd12,
		OP_RL    = 5'd13,
		OP_RLC   = 5'd14,
		OP_RR    = 5'd15,
		OP_RRC   = 5'd16,
		OP_SWAP  = 5'd17,
		OP_CLRC  = 5'd18,
		OP_CPLC  = 5'd19,
		OP_INCOP = 5'd20,
		OP_DECOP = 5'd21
	} op_t;

	// decimal adjust constants
	localparam logic [3:0] DA_LOW_LIMIT  = 4'h9;
	localparam logic [8:0] DA_HIGH_LIMIT = 9'h09f;
	localparam logic [8:0] DA_LOW_FIX    = 9'h006;
	localparam logic [8:0] DA_HIGH_FIX   = 9'h060;

	// request word
	typedef struct packed {
		logic [4:0] req_type;
		logic [7:0] operand_byte;
	} req_t;

	// result word
	typedef struct packed {
		logic [7:0] acc_out;
		logic       carry_out;
		logic       aux_carry_out;
		logic       acc_is_zero;
		logic [7:0] writeback_byte;
		logic       writeback_valid;
	} rsp_t;

	// accumulator and flags
	typedef struct packed {
		logic [7:0] acc;
		logic       cy;
		logic       ac;
	} state_t;

endpackage

>>> hw/rtl/aalu_if.sv
// ----------------------------------------------------------------------------
// aalu_if: valid/ready channels of the accumulator alu
// one channel for request words and one for result words.
// ----------------------------------------------------------------------------
interface aalu_req_if;
	logic          valid;
	logic          ready;
	aalu_pkg::req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface aalu_rsp_if;
	logic          valid;
	logic          ready;
	aalu_pkg::rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/aalu_exec.sv
// ----------------------------------------------------------------------------
// aalu_exec: single-pass alu datapath
// computes next accumulator and flags plus the result word for one operation.
// ----------------------------------------------------------------------------
module aalu_exec (
	input  aalu_pkg::req_t   req,
	input  aalu_pkg::state_t cur,
	output aalu_pkg::state_t nxt,
	output aalu_pkg::rsp_t   rsp
);

	logic [7:0] a;
	logic [7:0] v;
	logic       cin;
	logic [8:0] sum;
	logic [4:0] low;
	logic [8:0] da_t1;
	logic [8:0] da_t2;
	logic [7:0] wb;
	logic       wbv;

	assign a = cur.acc;
	assign v = req.operand_byte;

	// adder shared by add and addc
	assign cin = (aalu_pkg::op_t'(req.req_type) == aalu_pkg::OP_ADDC) ? cur.cy : 1'b0;
	assign sum = {1'b0, a} + {1'b0, v} + {8'd0, cin};
	assign low = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};

	// decimal adjust, low then high correction
	always_comb begin
		da_t1 = {1'b0, a};
		if (cur.ac || (a[3:0] > aalu_pkg::DA_LOW_LIMIT)) begin
			da_t1 = da_t1 + aalu_pkg::DA_LOW_FIX;
		end
		da_t2 = da_t1;
		if (cur.cy || (da_t1 > aalu_pkg::DA_HIGH_LIMIT)) begin
			da_t2 = da_t1 + aalu_pkg::DA_HIGH_FIX;
		end
	end

	// operation select
	always_comb begin
		nxt = cur;
		wb  = v;
		wbv = 1'b0;
		unique case (aalu_pkg::op_t'(req.req_type))
			aalu_pkg::OP_ADD, aalu_pkg::OP_ADDC: begin
				nxt.acc = sum[7:0];
				nxt.cy  = sum[8];
				nxt.ac  = low[4];
			end
			aalu_pkg::OP_AND:  nxt.acc = a & v;
			aalu_pkg::OP_OR:   nxt.acc = a | v;
			aalu_pkg::OP_XOR:  nxt.acc = a ^ v;
			aalu_pkg::OP_LOAD: nxt.acc = v;
			aalu_pkg::OP_XCH: begin
				nxt.acc = v;
				wb      = a;
				wbv     = 1'b1;
			end
			aalu_pkg::OP_XCHD: begin
				nxt.acc = {a[7:4], v[3:0]};
				wb      = {v[7:4], a[3:0]};
				wbv     = 1'b1;
			end
			aalu_pkg::OP_CLRA: nxt.acc = 8'd0;
			aalu_pkg::OP_CPLA: nxt.acc = ~a;
			aalu_pkg::OP_INCA: nxt.acc = a + 8'd1;
			aalu_pkg::OP_DECA: nxt.acc = a - 8'd1;
			aalu_pkg::OP_DA: begin
				nxt.acc = da_t2[7:0];
				nxt.cy  = cur.cy | da_t2[8];
			end
			aalu_pkg::OP_RL: nxt.acc = {a[6:0], a[7]};
			aalu_pkg::OP_RLC: begin
				nxt.acc = {a[6:0], cur.cy};
				nxt.cy  = a[7];
			end
			aalu_pkg::OP_RR: nxt.acc = {a[0], a[7:1]};
			aalu_pkg::OP_RRC: begin
				nxt.acc = {cur.cy, a[7:1]};
				nxt.cy  = a[0];
			end
			aalu_pkg::OP_SWAP: nxt.acc = {a[3:0], a[7:4]};
			aalu_pkg::OP_CLRC: nxt.cy = 1'b0;
			aalu_pkg::OP_CPLC: nxt.cy = ~cur.cy;
			aalu_pkg::OP_INCOP: begin
				wb  = v + 8'd1;
				wbv = 1'b1;
			end
			aalu_pkg::OP_DECOP: begin
				wb  = v - 8'd1;
				wbv = 1'b1;
			end
			default: begin
				// unused codes leave everything as is
			end
		endcase
	end

	// result word
	assign rsp.acc_out         = nxt.acc;
	assign rsp.carry_out       = nxt.cy;
	assign rsp.aux_carry_out   = nxt.ac;
	assign rsp.acc_is_zero     = (nxt.acc == 8'd0);
	assign rsp.writeback_byte  = wb;
	assign rsp.writeback_valid = wbv;

endmodule

>>> hw/rtl/accumulator_alu_8bit_core.sv
// ----------------------------------------------------------------------------
// accumulator_alu_8bit_core: 8-bit accumulator alu execute stage
// holds accumulator, carry and auxiliary carry; one operation per word.
// ----------------------------------------------------------------------------
// Each request word is captured in an input register and then executed
// against the accumulator and flags; the result lands in an output
// register at the same edge that the state is updated. The result word is
// valid once it has passed the input and then the output register, and one
// word is accepted every cycle while results are taken: the limit is the
// combinational alu path from the accumulator register through the adder or
// decimal adjust back to itself.
// After reset the accumulator and both flags are zero.
module accumulator_alu_8bit_core (
	input  logic              clk,
	input  logic              arst_n,
	aalu_req_if.sink          req,
	aalu_rsp_if.source        rsp
);

	logic             valid_s1;
	aalu_pkg::req_t   req_s1;
	aalu_pkg::state_t state_q;
	aalu_pkg::state_t state_nxt;
	aalu_pkg::rsp_t   rsp_nxt;
	aalu_pkg::rsp_t   rsp_q;
	logic             rsp_valid_q;
	logic             adv_out;

	// handshake: stage 1 moves when the output register is free or drains
	assign adv_out   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv_out;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_out) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.payload;
		end
	end

	// alu datapath
	aalu_exec u_exec (
		.req (req_s1),
		.cur (state_q),
		.nxt (state_nxt),
		.rsp (rsp_nxt)
	);

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_out) begin
			state_q <= state_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	// a pending result always matches the current state
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.acc_out == state_q.acc && rsp_q.carry_out == state_q.cy
			&& rsp_q.aux_carry_out == state_q.ac))
	else $error("pending result differs from accumulator state");

	// zero indication follows the reported accumulator
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.acc_is_zero == (rsp_q.acc_out == 8'd0)))
	else $error("zero indication inconsistent with accumulator");

	// only add and addc touch the auxiliary carry
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv_out && !(aalu_pkg::op_t'(req_s1.req_type) == aalu_pkg::OP_ADD
			|| aalu_pkg::op_t'(req_s1.req_type) == aalu_pkg::OP_ADDC))
		|=> (state_q.ac == $past(state_q.ac)))
	else $error("auxiliary carry changed by a non-add operation");

	// no accept while both stages are full and the output stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && rsp_valid_q && !rsp.ready) |-> !req.ready)
	else $error("request accepted with a full pipeline");

endmodule
